@@ rtl/core/strq_pkg.sv @@
// Shared types and constants for the segment tree range query block.
// Holds the controller/datapath command and status structs and the field codes.
// No dependencies.
package strq_pkg;

    // Fixed port widths of the item fields.
    localparam int IDX_A_W = 10;
    localparam int IDX_B_W = 11;
    localparam int VAL_W   = 32;
    localparam int RES_W   = 48;
    localparam int CFG_W   = 11;

    // Operation codes.
    localparam logic OP_UPDATE = 1'b0;
    localparam logic OP_QUERY  = 1'b1;

    // Register indexes.
    localparam logic CFG_MODE   = 1'b0;
    localparam logic CFG_LEAVES = 1'b1;

    // Combine modes; the unused code behaves as maximum.
    localparam logic [1:0] MODE_SUM = 2'd0;
    localparam logic [1:0] MODE_MIN = 2'd1;
    localparam logic [1:0] MODE_MAX = 2'd2;

    typedef struct packed {
        logic clr;
        logic load;
        logic upd_leaf;
        logic upd_rd;
        logic upd_wr;
        logic q_left;
        logic q_right;
        logic out_load;
    } t_dp_cmd;

    typedef struct packed {
        logic clr_last;
        logic in_query;
        logic in_skip;
        logic in_empty;
        logic lft_one;
        logic par_root;
        logic lt;
        logic out_free;
    } t_dp_stat;

endpackage

@@ rtl/core/strq_ctrl.sv @@
// Controller of the segment tree range query block.
// Sequences the clearing pass, leaf updates and range queries; uses strq_pkg.
module strq_ctrl
    import strq_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_dp_stat i_stat,
    output t_dp_cmd  o_cmd,
    output logic     o_in_stall
);

    localparam logic [2:0] S_CLR   = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_ULEAF = 3'd2;
    localparam logic [2:0] S_URD   = 3'd3;
    localparam logic [2:0] S_UWR   = 3'd4;
    localparam logic [2:0] S_QL    = 3'd5;
    localparam logic [2:0] S_QR    = 3'd6;
    localparam logic [2:0] S_DONE  = 3'd7;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_CLR: begin
                o_cmd.clr = 1'b1;
                if (i_stat.clr_last) begin
                    n_state = S_IDLE;
                end
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load = 1'b1;
                    if (i_stat.in_query) begin
                        n_state = i_stat.in_empty ? S_DONE : S_QL;
                    end else if (!i_stat.in_skip) begin
                        n_state = S_ULEAF;
                    end
                end
            end
            S_ULEAF: begin
                o_cmd.upd_leaf = 1'b1;
                n_state = i_stat.lft_one ? S_IDLE : S_URD;
            end
            S_URD: begin
                o_cmd.upd_rd = 1'b1;
                n_state = S_UWR;
            end
            S_UWR: begin
                o_cmd.upd_wr = 1'b1;
                n_state = i_stat.par_root ? S_IDLE : S_URD;
            end
            S_QL: begin
                // The read issued in the previous level is folded this cycle,
                // so the accumulator is final when the bounds meet.
                if (i_stat.lt) begin
                    o_cmd.q_left = 1'b1;
                    n_state = S_QR;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_QR: begin
                o_cmd.q_right = 1'b1;
                n_state = S_QL;
            end
            S_DONE: begin
                if (i_stat.out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign o_in_stall = (r_state != S_IDLE);

endmodule

@@ rtl/core/strq_dpath.sv @@
// Datapath of the segment tree range query block: node memory, bounds,
// accumulator, combine unit, configuration and output registers; uses strq_pkg.
module strq_dpath
    import strq_pkg::*;
#(
    parameter int LEAVES     = 1024,
    parameter int VALUE_BITS = 32,
    parameter int NODE_BITS  = 48
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [CFG_W-1:0]   i_cfg_data,
    input  logic               i_operation,
    input  logic [IDX_A_W-1:0] i_index_a,
    input  logic [IDX_B_W-1:0] i_index_b,
    input  logic [VAL_W-1:0]   i_leaf_value,
    input  logic               i_out_stall,
    input  t_dp_cmd            i_cmd,
    output t_dp_stat           o_stat,
    output logic               o_out_valid,
    output logic [RES_W-1:0]   o_result,
    output logic               o_empty_res
);

    localparam int NODES = 2 * LEAVES;
    localparam int AW    = $clog2(NODES);
    localparam int PW    = ((AW > CFG_W) ? AW : CFG_W) + 1;
    localparam logic [63:0] VMASK = (64'd1 << VALUE_BITS) - 64'd1;

    function automatic logic [NODE_BITS-1:0] f_merge(
        input logic [1:0]           mode,
        input logic [NODE_BITS-1:0] x,
        input logic [NODE_BITS-1:0] y
    );
        logic [NODE_BITS:0] s;
        s = {1'b0, x} + {1'b0, y};
        case (mode)
            MODE_SUM: f_merge = s[NODE_BITS] ? '1 : s[NODE_BITS-1:0];
            MODE_MIN: f_merge = (x < y) ? x : y;
            default:  f_merge = (x > y) ? x : y;
        endcase
    endfunction

    logic [NODE_BITS-1:0] r_mem [NODES];

    logic [1:0]           r_mode;
    logic [PW-1:0]        r_lcnt;
    logic [AW-1:0]        r_clr;
    logic [PW-1:0]        r_lft;
    logic [PW-1:0]        r_rgt;
    logic [NODE_BITS-1:0] r_val;
    logic [NODE_BITS-1:0] r_acc;
    logic                 r_have;
    logic                 r_qrd;
    logic [NODE_BITS-1:0] r_rdata;
    logic                 r_ovld;
    logic [RES_W-1:0]     r_res;
    logic                 r_empty;

    logic [PW-1:0]        n_cnt;
    logic [PW-1:0]        in_a;
    logic [PW-1:0]        in_b;
    logic [PW-1:0]        b_clamp;
    logic [63:0]          val_ext;
    logic [63:0]          acc_ext;
    logic [NODE_BITS-1:0] merged;
    logic                 rd_en;
    logic [AW-1:0]        rd_addr;
    logic                 wr_en;
    logic [AW-1:0]        wr_addr;
    logic [NODE_BITS-1:0] wr_data;
    logic                 q_rd;

    // Leaf count 0 acts as one leaf, anything above capacity as capacity.
    always_comb begin
        if (r_lcnt == '0) begin
            n_cnt = PW'(1);
        end else if (r_lcnt > PW'(LEAVES)) begin
            n_cnt = PW'(LEAVES);
        end else begin
            n_cnt = r_lcnt;
        end
        in_a    = PW'(i_index_a);
        in_b    = PW'(i_index_b);
        b_clamp = (in_b > n_cnt) ? n_cnt : in_b;
        val_ext = {{(64 - VAL_W){1'b0}}, i_leaf_value} & VMASK;
        acc_ext = 64'(r_acc);
        merged  = f_merge(r_mode, r_acc, r_rdata);
    end

    always_comb begin
        rd_en   = 1'b0;
        rd_addr = '0;
        q_rd    = 1'b0;
        wr_en   = 1'b0;
        wr_addr = '0;
        wr_data = '0;
        if (i_cmd.upd_rd) begin
            rd_en   = 1'b1;
            rd_addr = r_lft[AW-1:0] ^ AW'(1);
        end else if (i_cmd.q_left) begin
            rd_en   = r_lft[0];
            q_rd    = r_lft[0];
            rd_addr = r_lft[AW-1:0];
        end else if (i_cmd.q_right) begin
            // An odd right bound reads the node just left of it.
            rd_en   = r_rgt[0];
            q_rd    = r_rgt[0];
            rd_addr = {r_rgt[AW-1:1], 1'b0};
        end
        if (i_cmd.clr) begin
            wr_en   = 1'b1;
            wr_addr = r_clr;
        end else if (i_cmd.upd_leaf) begin
            wr_en   = 1'b1;
            wr_addr = r_lft[AW-1:0];
            wr_data = r_val;
        end else if (i_cmd.upd_wr) begin
            wr_en   = 1'b1;
            wr_addr = r_lft[AW:1];
            wr_data = merged;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_en) begin
            r_mem[wr_addr] <= wr_data;
        end
        if (rd_en) begin
            r_rdata <= r_mem[rd_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode <= MODE_SUM;
            r_lcnt <= PW'(LEAVES);
            r_clr  <= '0;
            r_have <= 1'b0;
            r_qrd  <= 1'b0;
            r_ovld <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                if (i_cfg_index == CFG_MODE) begin
                    r_mode <= i_cfg_data[1:0];
                end else if (i_cfg_index == CFG_LEAVES) begin
                    r_lcnt <= PW'(i_cfg_data);
                end
            end
            if (i_cmd.clr) begin
                r_clr <= r_clr + AW'(1);
            end
            r_qrd <= q_rd;
            if (i_cmd.load) begin
                r_have <= 1'b0;
            end else if (r_qrd) begin
                r_have <= 1'b1;
            end
            if (i_cmd.out_load) begin
                r_ovld <= 1'b1;
            end else if (!i_out_stall) begin
                r_ovld <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_lft <= n_cnt + in_a;
            r_rgt <= n_cnt + b_clamp;
            r_val <= val_ext[NODE_BITS-1:0];
        end else if (i_cmd.upd_wr) begin
            r_lft <= r_lft >> 1;
        end else if (i_cmd.q_left) begin
            r_lft <= r_lft + PW'(r_lft[0]);
        end else if (i_cmd.q_right) begin
            r_lft <= r_lft >> 1;
            r_rgt <= r_rgt >> 1;
        end
        if (i_cmd.upd_leaf) begin
            r_acc <= r_val;
        end else if (i_cmd.upd_wr) begin
            r_acc <= merged;
        end else if (r_qrd) begin
            r_acc <= r_have ? merged : r_rdata;
        end
        if (i_cmd.out_load) begin
            r_res   <= r_have ? acc_ext[RES_W-1:0] : '0;
            r_empty <= !r_have;
        end
    end

    always_comb begin
        o_stat.clr_last = (r_clr == AW'(NODES - 1));
        o_stat.in_query = (i_operation == OP_QUERY);
        o_stat.in_skip  = (in_a >= n_cnt);
        o_stat.in_empty = (in_a >= b_clamp);
        o_stat.lft_one  = (r_lft == PW'(1));
        o_stat.par_root = (r_lft[PW-1:1] == (PW-1)'(1));
        o_stat.lt       = (r_lft < r_rgt);
        o_stat.out_free = !r_ovld || !i_out_stall;
    end

    assign o_out_valid = r_ovld;
    assign o_result    = r_res;
    assign o_empty_res = r_empty;

endmodule

@@ rtl/core/segment_tree_range_query.sv @@
// Top level of the segment tree range query block.
// Joins strq_ctrl and strq_dpath; uses strq_pkg.
//
// Usage: an input beat on i_in_valid / o_in_stall carries an operation.
// A point update writes leaf index_a and recomputes its ancestors; it gives
// no output beat and is dropped when index_a is not below the leaf count.
// A range query combines leaves [index_a, min(index_b, leaf_count)) and gives
// one output beat on o_out_valid / i_out_stall with the result and an empty
// flag. Combining is by sum (saturating), minimum or maximum per combine_mode.
// Timing: one input beat at a time. An update writes the leaf, then, for each
// tree level above the leaf (10 at 1024 leaves), reads the sibling and writes
// the parent; a dropped update is absorbed without leaving the idle state. A
// query reads each level in a left step and a right step on the single read
// port; an empty range goes straight to the output stage.
// The output register lets the next item start while a result is stalled; a
// query that finishes while the output is still stalled waits in place.
// After reset the node memory is cleared one node per cycle, all 2*LEAVES
// nodes, with input stalled; configuration writes are taken at any time and
// are meant to be done while the block is idle.
module segment_tree_range_query
    import strq_pkg::*;
#(
    parameter int LEAVES     = 1024,
    parameter int VALUE_BITS = 32,
    parameter int NODE_BITS  = 48
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_index,
    input  logic [CFG_W-1:0]   i_cfg_data,
    input  logic               i_in_valid,
    output logic               o_in_stall,
    input  logic               i_operation,
    input  logic [IDX_A_W-1:0] i_index_a,
    input  logic [IDX_B_W-1:0] i_index_b,
    input  logic [VAL_W-1:0]   i_leaf_value,
    output logic               o_out_valid,
    input  logic               i_out_stall,
    output logic [RES_W-1:0]   o_result,
    output logic               o_empty_res
);

    t_dp_cmd  dp_cmd;
    t_dp_stat dp_stat;

    strq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .i_stat     (dp_stat),
        .o_cmd      (dp_cmd),
        .o_in_stall (o_in_stall)
    );

    strq_dpath #(
        .LEAVES     (LEAVES),
        .VALUE_BITS (VALUE_BITS),
        .NODE_BITS  (NODE_BITS)
    ) u_dpath (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_data   (i_cfg_data),
        .i_operation  (i_operation),
        .i_index_a    (i_index_a),
        .i_index_b    (i_index_b),
        .i_leaf_value (i_leaf_value),
        .i_out_stall  (i_out_stall),
        .i_cmd        (dp_cmd),
        .o_stat       (dp_stat),
        .o_out_valid  (o_out_valid),
        .o_result     (o_result),
        .o_empty_res  (o_empty_res)
    );

    // An empty range always reports a zero result.
    a_empty_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && o_empty_res |-> o_result == '0)
        else $error("empty result beat carries a nonzero value");

    // The clearing pass holds off input right after reset.
    a_clear_stall: assert property (@(posedge i_clk)
        $past(!i_rst_n) && i_rst_n |-> o_in_stall)
        else $error("input not stalled during clearing pass");

    // A new result never overwrites one that is still stalled.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        dp_cmd.out_load |-> (!o_out_valid || !i_out_stall))
        else $error("result register overwritten while stalled");

    // The controller issues at most one datapath command per cycle.
    a_one_cmd: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $onehot0(dp_cmd))
        else $error("more than one datapath command at once");

endmodule
